FILE: sv/szc_pkg.sv
// shared types, constants and tables for the solar zenith cosine unit
// no dependencies; imported by every design module of the unit
package szc_pkg;

  // one turn in 1/256 degree, and the divisor left after removing 2^11
  localparam int TURN_DEG256 = 92160;
  localparam int BANG_DIV = 45;

  // reciprocal of 45 for a 17-bit dividend, shift 23
  localparam logic [17:0] RECIP_45 = 18'd186414;

  // 2^32 / (2*pi), binary-angle units per radian scaled down
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;

  // cordic start vector, Q30
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  localparam int ATAN_LEN = 24;

  // atan(2^-i) in binary-angle units
  localparam logic signed [32:0] ATAN_TABLE [0:ATAN_LEN-1] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
    33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
    33'sd652,       33'sd326,       33'sd163,       33'sd81
  };

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MIN_DECL    = 2'd0,
    REG_DAY_OFFSET  = 2'd1,
    REG_RAD_PER_DAY = 2'd2
  } cfg_reg_t;

  // rotator state handed from cell to cell
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic               flip;
  } rot_t;

  // fraction of 2^21 for each remainder of 45
  typedef logic [20:0] frac_tab_t [0:63];

  function automatic frac_tab_t build_frac();
    frac_tab_t t;
    for (int k = 0; k < 64; k++) begin
      if (k < BANG_DIV) t[k] = 21'((longint'(k) << 21) / BANG_DIV);
      else t[k] = '0;
    end
    return t;
  endfunction

endpackage

FILE: sv/szc_cordic_cell.sv
// one rotation-mode cordic iteration with its pipeline register
// depends on szc_pkg
module szc_cordic_cell #(
  parameter int STAGE_IDX = 0
) (
  input  logic          clk,
  input  logic          adv,
  input  szc_pkg::rot_t rin,
  output szc_pkg::rot_t rout
);
  import szc_pkg::*;

  logic signed [32:0] xs;
  logic signed [32:0] ys;
  rot_t               nxt;

  // rotate toward zero residual angle
  always_comb begin
    xs = rin.x >>> STAGE_IDX;
    ys = rin.y >>> STAGE_IDX;
    nxt.flip = rin.flip;
    if (!rin.z[32]) begin
      nxt.x = rin.x - ys;
      nxt.y = rin.y + xs;
      nxt.z = rin.z - ATAN_TABLE[STAGE_IDX];
    end else begin
      nxt.x = rin.x + ys;
      nxt.y = rin.y - xs;
      nxt.z = rin.z + ATAN_TABLE[STAGE_IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) rout <= nxt;
  end

endmodule

FILE: sv/szc_cordic.sv
// pipelined sine and cosine: pre-rotation, a row of cordic cells, sign fix
// depends on szc_pkg and szc_cordic_cell
module szc_cordic #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic               adv,
  input  logic [31:0]        ang,
  output logic signed [31:0] cos_out,
  output logic signed [31:0] sin_out
);
  import szc_pkg::*;

  rot_t chain [0:STAGES];
  logic flip;
  logic [31:0] b;

  // fold quadrants two and three onto the right half plane
  always_comb begin
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    b    = flip ? ang + 32'h8000_0000 : ang;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chain[0].x    <= CORDIC_GAIN;
      chain[0].y    <= '0;
      chain[0].z    <= 33'($signed(b));
      chain[0].flip <= flip;
    end
  end

  // row of iteration cells
  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    szc_cordic_cell #(.STAGE_IDX(k)) u_cell (
      .clk  (clk),
      .adv  (adv),
      .rin  (chain[k]),
      .rout (chain[k+1])
    );
  end

  // undo the fold
  always_ff @(posedge clk) begin
    if (adv) begin
      cos_out <= chain[STAGES].flip ? 32'(-chain[STAGES].x) : 32'(chain[STAGES].x);
      sin_out <= chain[STAGES].flip ? 32'(-chain[STAGES].y) : 32'(chain[STAGES].y);
    end
  end

endmodule

FILE: sv/szc_deg2bang.sv
// maps an angle in [0, one turn) of 1/256 degree to a 32-bit binary angle
// depends on szc_pkg; three register stages
module szc_deg2bang (
  input  logic        clk,
  input  logic        adv,
  input  logic [16:0] deg,
  output logic [31:0] bang
);
  import szc_pkg::*;

  localparam frac_tab_t FRAC = build_frac();

  logic [34:0] prod;
  logic [16:0] deg_d;
  logic [10:0] quo;
  logic [5:0]  rem;
  logic [16:0] diff;

  // quotient by 45 through the reciprocal
  always_ff @(posedge clk) begin
    if (adv) begin
      prod  <= deg * RECIP_45;
      deg_d <= deg;
    end
  end

  // remainder
  assign diff = deg_d - 17'(prod[33:23]) * 17'd45;

  always_ff @(posedge clk) begin
    if (adv) begin
      quo <= prod[33:23];
      rem <= diff[5:0];
    end
  end

  // whole part times 2^21 plus fraction of the remainder
  always_ff @(posedge clk) begin
    if (adv) bang <= {quo, FRAC[rem]};
  end

endmodule

FILE: sv/solar_zenith_cosine_unit.sv
// solar zenith cosine unit, top level
// depends on szc_pkg, szc_deg2bang, szc_cordic
//
//  channel   signals                                           direction
//  input     in_valid, in_ready, latitude .. hour_of_day        in
//  output    out_valid, out_ready, zenith_cosine                out
//  config    cfg_write, cfg_index, cfg_data                     in
//
// one transaction per cycle while the output is not stalled
// two cordic rows in series set the latency: day angle, then declination
// reset clears the valid bits and loads the register defaults
// a stalled output freezes the whole pipeline; in_ready drops only then
module solar_zenith_cosine_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] latitude,
  input  logic signed [16:0] longitude,
  input  logic signed [16:0] zone_meridian,
  input  logic [8:0]         day_num,
  input  logic [4:0]         hour_of_day,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] zenith_cosine,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import szc_pkg::*;

  localparam int LAT_DLY = CORDIC_STAGES + 5;
  localparam int HA_DLY  = CORDIC_STAGES + 4;
  localparam int LAT_N   = 2 * CORDIC_STAGES + 14;
  localparam logic signed [30:0] INV_S = 31'($signed({1'b0, INV_TWO_PI}));

  logic adv;
  logic [LAT_N:1] vld;

  logic signed [13:0] min_declination;
  logic [11:0]        day_offset;
  logic [15:0]        radians_per_day;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_declination <= -14'sd6706;
      day_offset      <= 12'd180;
      radians_per_day <= 16'd18050;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_DECL:    min_declination <= $signed(cfg_data[13:0]);
        REG_DAY_OFFSET:  day_offset      <= cfg_data[11:0];
        REG_RAD_PER_DAY: radians_per_day <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the output register can take a value
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LAT_N];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAT_N-1:1], in_valid};
  end

  // first stage: reduce latitude, raw hour angle, day count
  logic [16:0]        lat_r;
  logic signed [18:0] ha_raw;
  logic [13:0]        day_arg;
  logic signed [17:0] lat_w;
  logic signed [18:0] hour_part;

  always_comb begin
    lat_w     = 18'(latitude);
    hour_part = $signed({14'd0, hour_of_day}) * 19'sd3840 - 19'sd46080;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lat_r   <= latitude[15] ? 17'(lat_w + 18'sd92160) : 17'(lat_w);
      ha_raw  <= hour_part + 19'(zone_meridian) - 19'(longitude);
      day_arg <= {1'b0, day_num, 4'd0} + {2'd0, day_offset};
    end
  end

  // hour angle into one turn
  logic [16:0] ha_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ha_raw < -19'sd92160) ha_r <= 17'(ha_raw + 19'sd184320);
      else if (ha_raw < 19'sd0) ha_r <= 17'(ha_raw + 19'sd92160);
      else if (ha_raw >= 19'sd184320) ha_r <= 17'(ha_raw - 19'sd184320);
      else if (ha_raw >= 19'sd92160) ha_r <= 17'(ha_raw - 19'sd92160);
      else ha_r <= ha_raw[16:0];
    end
  end

  // degree angles to binary angles
  logic [31:0] lat_bang;
  logic [31:0] ha_bang;

  szc_deg2bang u_lat_bang (.clk(clk), .adv(adv), .deg(lat_r), .bang(lat_bang));
  szc_deg2bang u_ha_bang  (.clk(clk), .adv(adv), .deg(ha_r),  .bang(ha_bang));

  // hold both until the declination angle is ready
  logic [31:0] lat_dly [0:LAT_DLY-1];
  logic [31:0] ha_dly  [0:HA_DLY-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      lat_dly[0] <= lat_bang;
      for (int k = 1; k < LAT_DLY; k++) lat_dly[k] <= lat_dly[k-1];
      ha_dly[0] <= ha_bang;
      for (int k = 1; k < HA_DLY; k++) ha_dly[k] <= ha_dly[k-1];
    end
  end

  // day angle: product, then scale to binary angle
  logic [29:0] day_prod;
  logic [59:0] day_scaled;

  always_ff @(posedge clk) begin
    if (adv) begin
      day_prod   <= day_arg * radians_per_day;
      day_scaled <= day_prod * INV_TWO_PI;
    end
  end

  logic signed [31:0] cos_day;
  logic signed [31:0] sin_day;

  szc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_day (
    .clk(clk), .adv(adv), .ang(day_scaled[55:24]), .cos_out(cos_day), .sin_out(sin_day)
  );

  // declination and its binary angle
  logic signed [45:0] decl_prod;
  logic signed [31:0] decl;
  logic signed [62:0] turn_prod;
  logic [31:0]        decl_bang;
  logic signed [45:0] decl_rnd;
  logic signed [62:0] turn_rnd;

  always_comb begin
    decl_rnd = decl_prod + 46'sd8192;
    turn_rnd = turn_prod + 63'sd536870912;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      decl_prod <= min_declination * cos_day;
      decl      <= decl_rnd[45:14];
      turn_prod <= decl * INV_S;
      decl_bang <= turn_rnd[61:30];
    end
  end

  // the three trig rows that meet at the combine stage
  logic signed [31:0] cos_lat, sin_lat, cos_decl, sin_decl, cos_ha, sin_ha;

  szc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lat (
    .clk(clk), .adv(adv), .ang(lat_dly[LAT_DLY-1]), .cos_out(cos_lat), .sin_out(sin_lat)
  );
  szc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_decl (
    .clk(clk), .adv(adv), .ang(decl_bang), .cos_out(cos_decl), .sin_out(sin_decl)
  );
  szc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_ha (
    .clk(clk), .adv(adv), .ang(ha_dly[HA_DLY-1]), .cos_out(cos_ha), .sin_out(sin_ha)
  );

  // combine: coslat*cosdecl*cosha + sinlat*sindecl, Q30 rounding
  logic signed [33:0] t_cc;
  logic signed [33:0] t_ss;
  logic signed [33:0] t_ss_d;
  logic signed [31:0] cos_ha_d;
  logic signed [35:0] t_ccc;
  logic signed [63:0] p_cc, p_ss;
  logic signed [65:0] p_ccc;
  logic signed [36:0] sum;
  logic signed [36:0] sum_rnd;
  logic signed [20:0] res;

  always_comb begin
    p_cc    = 64'(cos_lat * cos_decl) + 64'sd536870912;
    p_ss    = 64'(sin_lat * sin_decl) + 64'sd536870912;
    p_ccc   = 66'(t_cc * cos_ha_d) + 66'sd536870912;
    sum     = 37'(t_ccc) + 37'(t_ss_d);
    sum_rnd = sum + 37'sd32768;
    res     = sum_rnd[36:16];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_cc     <= p_cc[63:30];
      t_ss     <= p_ss[63:30];
      cos_ha_d <= cos_ha;
      t_ccc    <= p_ccc[65:30];
      t_ss_d   <= t_ss;
    end
  end

  // round to Q2.14 and clamp into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      if (res > 21'sd16384) zenith_cosine <= 16'sd16384;
      else if (res < -21'sd16384) zenith_cosine <= -16'sd16384;
      else zenith_cosine <= res[15:0];
    end
  end

endmodule

FILE: sv/szc_checker.sv
// port-level checks for the solar zenith cosine unit, bound to the top level
// depends on solar_zenith_cosine_unit ports only
module szc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] zenith_cosine
);

  // a waiting result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(zenith_cosine))
    else $error("output changed while stalled");

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result right after reset");

  // result stays inside the clamp
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> zenith_cosine <= 16'sd16384 && zenith_cosine >= -16'sd16384)
    else $error("result outside clamp");

  // input side is held only by a stalled result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input stalled without output stall");

endmodule

bind solar_zenith_cosine_unit szc_checker u_szc_checker (.*);
